FILE: hw/rtl/dcem_pkg.sv
// dcem_pkg: shared types, constants and helpers of the depth concavity edge map.
// No dependencies; used by dcem_nbr_unit and depth_concavity_edge_map.
package dcem_pkg;

  localparam int MAX_COLS  = 512;
  localparam int MAX_ROWS  = 512;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int DIM_W     = 10;
  localparam int SLOT_W    = 2;             // four row slots in the line store
  localparam int ADDR_W    = SLOT_W + COL_W;
  localparam int CNT_W     = 4;
  localparam logic [CNT_W-1:0] CNT_CTR   = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_NB_LO = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_NB_HI = CNT_W'(8);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(15);

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_COLS      = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(320);
  localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(240);
  localparam logic signed [15:0] THR_RST = 16'sd15565;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_OUT
  } dcem_state_e;

  // one line store entry
  typedef struct packed {
    logic [15:0]        depth;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
    logic signed [19:0] vz;
    logic signed [19:0] vy;
    logic signed [19:0] vx;
  } dcem_pix_t;

  localparam int PIX_W = $bits(dcem_pix_t);

  typedef struct packed {
    logic clr;       // start of an evaluation
    logic ctr_cap;   // read data holds the center pixel
    logic nb_issue;  // in-frame neighbour read issued this cycle
  } dcem_ctl_t;

  // neighbour k: row offset code 0 up, 1 same, 2 down
  function automatic logic [1:0] nb_row(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // neighbour k: column offset code 0 left, 1 same, 2 right
  function automatic logic [1:0] nb_col(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0, 3'd3, 3'd5: c = 2'd0;
      3'd1, 3'd6:       c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

FILE: hw/rtl/dcem_ram.sv
// dcem_ram: single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module dcem_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/dcem_nbr_unit.sv
// dcem_nbr_unit: pipelined neighbour arithmetic (distance, penalty, min/max)
// and the final threshold and noise decision. Uses dcem_pkg.
module dcem_nbr_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcem_pkg::dcem_ctl_t ctl_i,
  input  dcem_pkg::dcem_pix_t rd_i,
  input  logic signed [15:0]  thr_i,
  output logic                edge_free_o
);

  localparam logic signed [33:0] PEN_ONE = 34'sd268435456;
  localparam logic [20:0]        NOISE_K = 21'd1953125;

  // center pixel
  logic signed [19:0] cv_q [3];
  logic signed [15:0] cn_q [3];
  logic [15:0]        cd_q;

  logic signed [19:0] vn [3];
  logic signed [15:0] nn [3];

  always_comb begin
    vn[0] = rd_i.vx; vn[1] = rd_i.vy; vn[2] = rd_i.vz;
    nn[0] = rd_i.nx; nn[1] = rd_i.ny; nn[2] = rd_i.nz;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ctr_cap) begin
      cv_q <= vn;
      cn_q <= nn;
      cd_q <= rd_i.depth;
    end
  end

  // stage valids
  logic vr_q, va_q, vb_q, vc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      vr_q <= ctl_i.nb_issue;
      va_q <= vr_q;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // stage A: vertex differences
  logic signed [20:0] diff_q [3];
  logic signed [15:0] nn_q   [3];
  // stage B: products
  logic signed [36:0] pd_q [3];
  logic signed [31:0] pp_q [3];
  // stage C: sums
  logic signed [38:0] dist_q;
  logic signed [33:0] pen_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      diff_q[k] <= {vn[k][19], vn[k]} - {cv_q[k][19], cv_q[k]};
      nn_q[k]   <= nn[k];
      pd_q[k]   <= cn_q[k] * diff_q[k];
      pp_q[k]   <= cn_q[k] * nn_q[k];
    end
    dist_q <= 39'(pd_q[0]) + 39'(pd_q[1]) + 39'(pd_q[2]);
    pen_q  <= 34'(pp_q[0]) + 34'(pp_q[1]) + 34'(pp_q[2]);
  end

  // stage D: running min penalty and max |dist|
  logic               have_q;
  logic signed [33:0] minpen_q;
  logic [38:0]        maxd_q;
  logic signed [33:0] pen_eff;
  logic [38:0]        ad;

  always_comb begin
    pen_eff = (dist_q > 39'sd0) ? PEN_ONE : pen_q;
    ad      = dist_q[38] ? 39'(-dist_q) : 39'(dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (ctl_i.clr) begin
      have_q <= 1'b0;
    end else if (vc_q) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vc_q) begin
      if (!have_q || pen_eff < minpen_q) minpen_q <= pen_eff;
      if (!have_q || ad > maxd_q) maxd_q <= ad;
    end
  end

  // noise test: maxd*5^9 > (12e6 + 19*(d-400)^2) << 16, split multiply
  logic [40:0]        plo_q;
  logic [39:0]        phi_q;
  logic [33:0]        dfsq_q;
  logic [59:0]        lhs_q;
  logic [36:0]        t_q;
  logic signed [16:0] df;
  logic signed [33:0] dfsq;

  always_comb begin
    df   = $signed({1'b0, cd_q}) - 17'sd400;
    dfsq = df * df;
  end

  always_ff @(posedge clk_i) begin
    plo_q  <= maxd_q[19:0] * NOISE_K;
    phi_q  <= maxd_q[38:20] * NOISE_K;
    dfsq_q <= $unsigned(dfsq);
    lhs_q  <= {phi_q, 20'b0} + 60'(plo_q);
    t_q    <= 37'd12000000 + 37'(dfsq_q) * 37'd19;
  end

  logic noise, thr_ok;
  always_comb begin
    noise  = lhs_q > {7'b0, t_q, 16'b0};
    thr_ok = minpen_q > 34'($signed({thr_i, 14'b0}));
    edge_free_o = (cd_q != 16'd0) && (!have_q || (thr_ok && !noise));
  end

endmodule

FILE: hw/rtl/depth_concavity_edge_map.sv
// depth_concavity_edge_map: top level; frame counters, line store and sequencer.
// Uses dcem_pkg, dcem_ram and dcem_nbr_unit.
//
//  channel   dir   handshake              payload
//  s_axis    in    tvalid/tready          tdata pixel fields, tuser cmd
//  m_axis    out   tvalid/tready          tdata edge_free, tlast frame_end
//  cfg       in    cfg_we_i               cfg_idx_i, cfg_data_i
//
// A request without a result leaves the sequencer idle; a request with a result
// starts an evaluation: one line store read per cycle for the center and eight
// neighbours, then the arithmetic pipeline drains and the result is registered.
// The output register parts the channels; a stalled result holds the sequencer
// only when the next result is ready. Reset clears control state only; the
// line store needs no clearing since only pixels of the current frame are read.
module depth_concavity_edge_map (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] depth_mm, [35:16] vertex_x, [55:36] vertex_y, [75:56] vertex_z,
  // [91:76] normal_x, [107:92] normal_y, [123:108] normal_z, rest zero
  input  logic [127:0] s_axis_tdata,
  // [0] cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] edge_free, rest zero
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int DW = dcem_pkg::DIM_W;
  localparam int CW = dcem_pkg::COL_W;
  localparam int RW = dcem_pkg::ROW_W;
  localparam logic [DW-1:0] MAXC = DW'(dcem_pkg::MAX_COLS);
  localparam logic [DW-1:0] MAXR = DW'(dcem_pkg::MAX_ROWS);

  // configuration
  logic signed [15:0] thr_q;
  logic [DW-1:0]      fcols_q, frows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= dcem_pkg::THR_RST;
      fcols_q <= dcem_pkg::COLS_RST;
      frows_q <= dcem_pkg::ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dcem_pkg::CFG_THRESHOLD: thr_q   <= cfg_data_i;
        dcem_pkg::CFG_COLS:      fcols_q <= cfg_data_i[DW-1:0];
        dcem_pkg::CFG_ROWS:      frows_q <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  dcem_pkg::dcem_state_e state_q, state_d;
  logic [dcem_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0] in_row_q, in_row_d, res_row_q, res_row_d;
  logic [CW-1:0] in_col_q, in_col_d, res_col_q, res_col_d;
  logic [DW-1:0] cols_l_q, cols_l_d, rows_l_q, rows_l_d;
  logic [DW-1:0] lag_q, lag_d;
  logic [RW-1:0] ev_i_q, ev_i_d;
  logic [CW-1:0] ev_j_q, ev_j_d;
  logic          ev_last_q, ev_last_d;
  logic          m_valid_q, m_valid_d, m_ef_q, m_ef_d, m_last_q, m_last_d;

  logic acc, is_pix, newfr, emit;
  logic [DW-1:0] e_cols, e_rows, e_irow, e_rrow, e_lag, lag_n;
  logic [CW-1:0] e_icol, e_rcol;

  logic                        we;
  logic [dcem_pkg::ADDR_W-1:0] waddr, raddr;
  dcem_pkg::dcem_pix_t         wpix, rpix;
  dcem_pkg::dcem_ctl_t         ctl;
  logic                        unit_ef;

  logic [2:0] k;
  logic [1:0] rc, cc;
  logic       nb_ok;
  logic [1:0] rslot;
  logic [CW-1:0] rcol;

  assign s_axis_tready = (state_q == dcem_pkg::ST_IDLE);
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign is_pix = (s_axis_tuser == dcem_pkg::CMD_PIXEL);

  always_comb begin
    wpix.depth = s_axis_tdata[15:0];
    wpix.vx    = s_axis_tdata[35:16];
    wpix.vy    = s_axis_tdata[55:36];
    wpix.vz    = s_axis_tdata[75:56];
    wpix.nx    = s_axis_tdata[91:76];
    wpix.ny    = s_axis_tdata[107:92];
    wpix.nz    = s_axis_tdata[123:108];
  end

  // frame bookkeeping for an accepted request
  always_comb begin
    newfr  = is_pix && (((in_row_q == '0) && (in_col_q == '0)) || (in_row_q == rows_l_q));
    e_cols = newfr ? dcem_pkg::clamp_dim(fcols_q, MAXC) : cols_l_q;
    e_rows = newfr ? dcem_pkg::clamp_dim(frows_q, MAXR) : rows_l_q;
    e_irow = newfr ? '0 : in_row_q;
    e_icol = newfr ? '0 : in_col_q;
    e_rrow = newfr ? '0 : res_row_q;
    e_rcol = newfr ? '0 : res_col_q;
    e_lag  = newfr ? '0 : lag_q;
    lag_n  = e_lag + DW'(1);
    if (is_pix) begin
      emit = (lag_n >= e_cols + DW'(2)) && (e_rrow < e_rows);
    end else begin
      emit = (in_row_q == rows_l_q) && (res_row_q < rows_l_q);
    end
  end

  // neighbour addressing
  always_comb begin
    k     = 3'(cnt_q - dcem_pkg::CNT_NB_LO);
    rc    = dcem_pkg::nb_row(k);
    cc    = dcem_pkg::nb_col(k);
    nb_ok = 1'b1;
    if (rc == 2'd0 && ev_i_q == '0) nb_ok = 1'b0;
    if (rc == 2'd2 && ({1'b0, ev_i_q} + DW'(1)) >= rows_l_q) nb_ok = 1'b0;
    if (cc == 2'd0 && ev_j_q == '0) nb_ok = 1'b0;
    if (cc == 2'd2 && ({1'b0, ev_j_q} + DW'(1)) >= cols_l_q) nb_ok = 1'b0;
    if (cnt_q == dcem_pkg::CNT_CTR) begin
      rslot = ev_i_q[1:0];
      rcol  = ev_j_q;
    end else begin
      rslot = ev_i_q[1:0] + rc - 2'd1;
      rcol  = ev_j_q + {{(CW-2){1'b0}}, cc} - CW'(1);
    end
    raddr = {rslot, rcol};
  end

  always_comb begin
    ctl.clr      = (state_q == dcem_pkg::ST_EVAL) && (cnt_q == dcem_pkg::CNT_CTR);
    ctl.ctr_cap  = (state_q == dcem_pkg::ST_EVAL) && (cnt_q == dcem_pkg::CNT_CAP);
    ctl.nb_issue = (state_q == dcem_pkg::ST_EVAL) && (cnt_q >= dcem_pkg::CNT_NB_LO)
                   && (cnt_q <= dcem_pkg::CNT_NB_HI) && nb_ok;
  end

  assign we    = acc && is_pix;
  assign waddr = {e_irow[1:0], e_icol};

  dcem_ram #(
    .DW(dcem_pkg::PIX_W),
    .AW(dcem_pkg::ADDR_W)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wpix),
    .re_i    (state_q == dcem_pkg::ST_EVAL),
    .raddr_i (raddr),
    .rdata_o (rpix)
  );

  dcem_nbr_unit u_nbr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rd_i        (rpix),
    .thr_i       (thr_q),
    .edge_free_o (unit_ef)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    res_row_d = res_row_q;
    res_col_d = res_col_q;
    cols_l_d  = cols_l_q;
    rows_l_d  = rows_l_q;
    lag_d     = lag_q;
    ev_i_d    = ev_i_q;
    ev_j_d    = ev_j_q;
    ev_last_d = ev_last_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_ef_d    = m_ef_q;
    m_last_d  = m_last_q;
    unique case (state_q)
      dcem_pkg::ST_IDLE: begin
        if (acc) begin
          if (is_pix) begin
            cols_l_d = e_cols;
            rows_l_d = e_rows;
            if (({1'b0, e_icol} + DW'(1)) == e_cols) begin
              in_col_d = '0;
              in_row_d = e_irow + DW'(1);
            end else begin
              in_col_d = e_icol + CW'(1);
              in_row_d = e_irow;
            end
            lag_d     = emit ? e_lag : lag_n;
            res_row_d = e_rrow;
            res_col_d = e_rcol;
          end
          if (emit) begin
            ev_i_d    = e_rrow[RW-1:0];
            ev_j_d    = e_rcol;
            ev_last_d = (({1'b0, e_rcol} + DW'(1)) == e_cols) &&
                        ((e_rrow + DW'(1)) == e_rows);
            if (({1'b0, e_rcol} + DW'(1)) == e_cols) begin
              res_col_d = '0;
              res_row_d = e_rrow + DW'(1);
            end else begin
              res_col_d = e_rcol + CW'(1);
              res_row_d = e_rrow;
            end
            cnt_d   = dcem_pkg::CNT_CTR;
            state_d = dcem_pkg::ST_EVAL;
          end
        end
      end
      dcem_pkg::ST_EVAL: begin
        cnt_d = cnt_q + dcem_pkg::CNT_W'(1);
        if (cnt_q == dcem_pkg::CNT_LAST) state_d = dcem_pkg::ST_OUT;
      end
      dcem_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_ef_d    = unit_ef;
          m_last_d  = ev_last_q;
          state_d   = dcem_pkg::ST_IDLE;
        end
      end
      default: state_d = dcem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dcem_pkg::ST_IDLE;
      cnt_q     <= '0;
      in_row_q  <= '0;
      in_col_q  <= '0;
      res_row_q <= '0;
      res_col_q <= '0;
      cols_l_q  <= dcem_pkg::COLS_RST;
      rows_l_q  <= dcem_pkg::ROWS_RST;
      lag_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      res_row_q <= res_row_d;
      res_col_q <= res_col_d;
      cols_l_q  <= cols_l_d;
      rows_l_q  <= rows_l_d;
      lag_q     <= lag_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_i_q    <= ev_i_d;
    ev_j_q    <= ev_j_d;
    ev_last_q <= ev_last_d;
    m_ef_q    <= m_ef_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_ef_q};
  assign m_axis_tlast  = m_last_q;

  // pending pixels never exceed one row plus one
  a_lag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q <= cols_l_q + DW'(1))
    else $error("pixel lag beyond one row");

  // results never run ahead of received pixels
  a_res_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_row_q < in_row_q) || ((res_row_q == in_row_q) && (res_col_q <= in_col_q)))
    else $error("result position passed input position");

  // sequencer always ends in the output state
  a_eval_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcem_pkg::ST_EVAL) && (cnt_q == dcem_pkg::CNT_LAST)
    |=> (state_q == dcem_pkg::ST_OUT))
    else $error("evaluation did not finish");

  // a new result only comes from the output state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == dcem_pkg::ST_OUT))
    else $error("result appeared outside output state");

endmodule
